FILE: design/tcw_pkg.sv
// tcw_pkg: shared types and constants for the tcp reno congestion window block
package tcw_pkg;

	localparam int SEQ_W     = 32;
	localparam int MSS_W     = 16;
	localparam int CNT_W     = 8;
	localparam int CFG_IDX_W = 1;

	localparam int DEFAULT_SEGMENT_SIZE_C = 1460;

	localparam logic [CFG_IDX_W-1:0] CFG_MSS    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 1'd1;

	localparam logic [SEQ_W-1:0] THRESH_RST = 32'd65535;
	localparam logic [CNT_W-1:0] DUP_MAX    = 8'hFF;
	localparam logic [CNT_W-1:0] DUP_ENTER  = 8'd3;

	typedef enum logic [1:0] {
		CLS_NEW     = 2'd0,
		CLS_DUP     = 2'd1,
		CLS_OTHER   = 2'd2,
		CLS_TIMEOUT = 2'd3
	} cls_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DIV,
		ST_DONE
	} ctl_state_t;

	typedef struct packed {
		logic capture;
		logic eval;
		logic div_start;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_done;
		logic out_free;
	} sts_t;

endpackage

FILE: design/tcw_div.sv
// tcw_div: restoring unsigned divider, one quotient bit per cycle
module tcw_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [tcw_pkg::SEQ_W-1:0] dividend,
	input  logic [tcw_pkg::SEQ_W-1:0] divisor,
	output logic                     done,
	output logic [tcw_pkg::SEQ_W-1:0] quotient
);
	import tcw_pkg::*;

	localparam int CW = $clog2(SEQ_W);

	logic            busy_q;
	logic            done_q;
	logic [CW-1:0]   cnt_q;
	logic [SEQ_W-1:0] rem_q;
	logic [SEQ_W-1:0] quo_q;
	logic [SEQ_W-1:0] dsr_q;
	logic [SEQ_W:0]   shifted;
	logic [SEQ_W:0]   diff;
	logic            fits;

	// shift in the next dividend bit and try the subtract
	assign shifted = {rem_q, quo_q[SEQ_W-1]};
	assign diff    = shifted - {1'b0, dsr_q};
	assign fits    = !diff[SEQ_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			// last quotient bit goes in at this edge
			done_q <= !start && busy_q && (cnt_q == CW'(SEQ_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(SEQ_W - 1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[SEQ_W-1:0] : shifted[SEQ_W-1:0];
			quo_q <= {quo_q[SEQ_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

FILE: design/tcw_datapath.sv
// tcw_datapath: flow state, ack classification, window arithmetic and result register
module tcw_datapath #(
	parameter int DEFAULT_SEGMENT_SIZE = tcw_pkg::DEFAULT_SEGMENT_SIZE_C
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tcw_pkg::cmd_t                cmd,
	output tcw_pkg::sts_t                sts,
	input  logic                         mode,
	input  logic [tcw_pkg::SEQ_W-1:0]    ack_number,
	input  logic [tcw_pkg::SEQ_W-1:0]    send_unacked,
	input  logic [tcw_pkg::SEQ_W-1:0]    send_next,
	input  logic                         carries_data_or_fin,
	input  logic                         cfg_we,
	input  logic [tcw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tcw_pkg::SEQ_W-1:0]    cfg_data,
	input  logic                         result_ready,
	output logic                         result_valid,
	output logic [1:0]                   ack_class,
	output logic [tcw_pkg::SEQ_W-1:0]    congestion_window,
	output logic [tcw_pkg::SEQ_W-1:0]    slow_start_threshold,
	output logic                         fast_recovery,
	output logic [tcw_pkg::CNT_W-1:0]    duplicate_count,
	output logic                         retransmit_request
);
	import tcw_pkg::*;

	localparam logic [MSS_W-1:0] MSS_DEF    = MSS_W'(DEFAULT_SEGMENT_SIZE);
	localparam logic [SEQ_W-1:0] MSS_SQ_DEF =
		SEQ_W'(longint'(DEFAULT_SEGMENT_SIZE) * longint'(DEFAULT_SEGMENT_SIZE));

	function automatic logic [SEQ_W-1:0] sat_add(input logic [SEQ_W-1:0] a,
			input logic [SEQ_W-1:0] b);
		logic [SEQ_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[SEQ_W] ? '1 : s[SEQ_W-1:0];
	endfunction

	// flow state
	logic [MSS_W-1:0] mss_q;
	logic [SEQ_W-1:0] mss_sq_q;
	logic [SEQ_W-1:0] win_q;
	logic [SEQ_W-1:0] thr_q;
	logic             rec_q;
	logic [SEQ_W-1:0] rp_q;
	logic [CNT_W-1:0] dup_q;

	// captured word
	logic             mode_q;
	logic [SEQ_W-1:0] ack_q;
	logic [SEQ_W-1:0] una_q;
	logic [SEQ_W-1:0] nxt_q;
	logic             dat_q;

	// evaluation results
	cls_t             cls_q;
	logic [SEQ_W-1:0] half_q;

	// result register
	logic             res_valid_q;
	logic [1:0]       res_cls_q;
	logic [SEQ_W-1:0] res_win_q;
	logic [SEQ_W-1:0] res_thr_q;
	logic             res_rec_q;
	logic [CNT_W-1:0] res_dup_q;
	logic             res_rex_q;

	logic [MSS_W-1:0] cfg_mss;
	cls_t             cls_c;
	logic [SEQ_W-1:0] flight;
	logic [SEQ_W-1:0] half_c;
	logic [SEQ_W-1:0] floor2;
	logic [SEQ_W-1:0] mss_w;
	logic [SEQ_W-1:0] mss3;
	logic [SEQ_W-1:0] divisor;
	logic [SEQ_W-1:0] quo;
	logic [SEQ_W-1:0] inc;
	logic             div_done;
	logic [CNT_W-1:0] dup_inc;

	logic [SEQ_W-1:0] win_n;
	logic [SEQ_W-1:0] thr_n;
	logic             rec_n;
	logic [SEQ_W-1:0] rp_n;
	logic [CNT_W-1:0] dup_n;
	logic             rex_n;

	assign cfg_mss = (cfg_data[MSS_W-1:0] == '0) ? MSS_DEF : cfg_data[MSS_W-1:0];
	assign mss_w   = {{(SEQ_W-MSS_W){1'b0}}, mss_q};
	assign floor2  = {{(SEQ_W-MSS_W-1){1'b0}}, mss_q, 1'b0};
	assign mss3    = floor2 + mss_w;

	// classify the captured word
	always_comb begin
		if (mode_q)
			cls_c = CLS_TIMEOUT;
		else if (ack_q > una_q && ack_q <= nxt_q)
			cls_c = CLS_NEW;
		else if (ack_q == una_q && !dat_q)
			cls_c = CLS_DUP;
		else
			cls_c = CLS_OTHER;
	end

	// half the flight, never below two segments
	assign flight = (nxt_q > una_q) ? (nxt_q - una_q) : '0;
	assign half_c = ((flight >> 1) < floor2) ? floor2 : (flight >> 1);

	assign divisor = (win_q == '0) ? SEQ_W'(1) : win_q;

	tcw_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (mss_sq_q),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (quo)
	);

	assign inc     = (quo == '0) ? SEQ_W'(1) : quo;
	assign dup_inc = (dup_q == DUP_MAX) ? DUP_MAX : dup_q + 1'b1;

	// next flow state at commit
	always_comb begin
		win_n = win_q;
		thr_n = thr_q;
		rec_n = rec_q;
		rp_n  = rp_q;
		dup_n = dup_q;
		rex_n = 1'b0;
		case (cls_q)
			CLS_TIMEOUT: begin
				thr_n = half_q;
				win_n = mss_w;
				dup_n = '0;
				rec_n = 1'b0;
				rp_n  = '0;
			end
			CLS_NEW: begin
				dup_n = '0;
				if (rec_q) begin
					win_n = (thr_q < mss_w) ? mss_w : thr_q;
					if (ack_q >= rp_q)
						rec_n = 1'b0;
				end else if (win_q < thr_q) begin
					win_n = sat_add(win_q, mss_w);
				end else begin
					win_n = sat_add(win_q, inc);
				end
			end
			CLS_DUP: begin
				dup_n = dup_inc;
				if (rec_q) begin
					win_n = sat_add(win_q, mss_w);
				end else if (dup_inc == DUP_ENTER) begin
					thr_n = half_q;
					rp_n  = nxt_q;
					win_n = sat_add(half_q, mss3);
					rec_n = 1'b1;
					rex_n = 1'b1;
				end
			end
			default: begin
				dup_n = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mss_q    <= MSS_DEF;
			mss_sq_q <= MSS_SQ_DEF;
			win_q    <= {{(SEQ_W-MSS_W){1'b0}}, MSS_DEF};
			thr_q    <= THRESH_RST;
			rec_q    <= 1'b0;
			rp_q     <= '0;
			dup_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MSS: begin
					mss_q    <= cfg_mss;
					mss_sq_q <= SEQ_W'(cfg_mss) * SEQ_W'(cfg_mss);
					win_q    <= {{(SEQ_W-MSS_W){1'b0}}, cfg_mss};
				end
				CFG_THRESH: begin
					thr_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end else if (cmd.commit) begin
			win_q <= win_n;
			thr_q <= thr_n;
			rec_q <= rec_n;
			rp_q  <= rp_n;
			dup_q <= dup_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= mode;
			ack_q  <= ack_number;
			una_q  <= send_unacked;
			nxt_q  <= send_next;
			dat_q  <= carries_data_or_fin;
		end
		if (cmd.eval) begin
			cls_q  <= cls_c;
			half_q <= half_c;
		end
		if (cmd.commit) begin
			res_cls_q <= cls_q;
			res_win_q <= win_n;
			res_thr_q <= thr_n;
			res_rec_q <= rec_n;
			res_dup_q <= dup_n;
			res_rex_q <= rex_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (cmd.commit)
			res_valid_q <= 1'b1;
		else if (result_ready)
			res_valid_q <= 1'b0;
	end

	assign sts.need_div = (cls_c == CLS_NEW) && !rec_q && !(win_q < thr_q);
	assign sts.div_done = div_done;
	assign sts.out_free = !res_valid_q || result_ready;

	assign result_valid         = res_valid_q;
	assign ack_class            = res_cls_q;
	assign congestion_window    = res_win_q;
	assign slow_start_threshold = res_thr_q;
	assign fast_recovery        = res_rec_q;
	assign duplicate_count      = res_dup_q;
	assign retransmit_request   = res_rex_q;

endmodule

FILE: design/tcw_ctrl.sv
// tcw_ctrl: sequencing state machine for one word at a time
module tcw_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_ready,
	input  tcw_pkg::sts_t sts,
	output tcw_pkg::cmd_t cmd
);
	import tcw_pkg::*;

	ctl_state_t state_q;
	ctl_state_t state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_n;
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: if (item_valid) state_n = ST_EVAL;
			ST_EVAL: state_n = sts.need_div ? ST_DIV : ST_DONE;
			ST_DIV:  if (sts.div_done) state_n = ST_DONE;
			ST_DONE: if (sts.out_free) state_n = ST_IDLE;
			default: state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		item_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item_ready  = 1'b1;
				cmd.capture = item_valid;
			end
			ST_EVAL: begin
				cmd.eval      = 1'b1;
				cmd.div_start = sts.need_div;
			end
			ST_DIV: begin
			end
			ST_DONE: begin
				cmd.commit = sts.out_free;
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: design/tcp_reno_congestion_window.sv
// tcp_reno_congestion_window: top level of the per-flow congestion window keeper
//
//  channel  signals                                    direction  width of data
//  item     item_valid/item_ready + five ack fields    in         1/32/32/32/1
//  result   result_valid/result_ready + six fields     out        2/32/32/1/8/1
//  cfg      cfg_valid/cfg_ready, cfg_index, cfg_data   in         1 + 32
//
// a word goes from accept to result through capture, classify and commit, with a divide
// added when congestion avoidance needs mss*mss/cwnd from the 32-step serial divider
// the result sits in an output register, so the next word is taken while it waits
// reset loads cwnd with the default segment size and ssthresh with 65535
// cfg_ready is always high; writes are meant to land while no word is in flight
module tcp_reno_congestion_window #(
	parameter int DEFAULT_SEGMENT_SIZE = tcw_pkg::DEFAULT_SEGMENT_SIZE_C
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// ack / timer words
	input  logic                          item_valid,
	output logic                          item_ready,
	input  logic                          mode,
	input  logic [tcw_pkg::SEQ_W-1:0]     ack_number,
	input  logic [tcw_pkg::SEQ_W-1:0]     send_unacked,
	input  logic [tcw_pkg::SEQ_W-1:0]     send_next,
	input  logic                          carries_data_or_fin,
	// result words
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic [1:0]                    ack_class,
	output logic [tcw_pkg::SEQ_W-1:0]     congestion_window,
	output logic [tcw_pkg::SEQ_W-1:0]     slow_start_threshold,
	output logic                          fast_recovery,
	output logic [tcw_pkg::CNT_W-1:0]     duplicate_count,
	output logic                          retransmit_request,
	// register writes
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tcw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tcw_pkg::SEQ_W-1:0]     cfg_data
);
	import tcw_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// writes are never back-pressured
	assign cfg_ready = 1'b1;

	// controller: idle, classify, optional divide, commit
	tcw_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	// datapath: flow state, arithmetic, divider and result register
	tcw_datapath #(
		.DEFAULT_SEGMENT_SIZE (DEFAULT_SEGMENT_SIZE)
	) u_datapath (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cmd                  (cmd),
		.sts                  (sts),
		.mode                 (mode),
		.ack_number           (ack_number),
		.send_unacked         (send_unacked),
		.send_next            (send_next),
		.carries_data_or_fin  (carries_data_or_fin),
		.cfg_we               (cfg_valid),
		.cfg_index            (cfg_index),
		.cfg_data             (cfg_data),
		.result_ready         (result_ready),
		.result_valid         (result_valid),
		.ack_class            (ack_class),
		.congestion_window    (congestion_window),
		.slow_start_threshold (slow_start_threshold),
		.fast_recovery        (fast_recovery),
		.duplicate_count      (duplicate_count),
		.retransmit_request   (retransmit_request)
	);

endmodule
